>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at an edge implies consequent at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lookat_pkg.sv
// Shared constants, types and the arctangent table of the look-at angle core.
`timescale 1ns / 1ps

package lookat_pkg;

    // Default configuration.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 12;

    // Field widths.
    localparam int SUBJ_W  = 32;
    localparam int EYE_W   = 20;
    localparam int SCALE_W = 24;
    localparam int EYE_SHIFT = 4;
    localparam int FRAC_W  = 12;

    // Internal widths.
    localparam int D_W   = 22;  // relative vector component
    localparam int VEC_W = 46;  // operand of the arctangent unit
    localparam int MAG_W = 53;  // normalized magnitude, leading one at bit 52
    localparam int CX_W  = 56;  // rotation datapath
    localparam int Z_W   = 34;  // angle accumulator, 2^32 per turn

    localparam int Y_LIFT  = 40;
    localparam int TAB_LEN = 24;

    // Pipeline depths outside the rotation stages.
    localparam int VEC_LAT   = 3;
    localparam int ATAN_FIX_LAT = 5;

    // Angle constants in accumulator units.
    localparam logic signed [Z_W-1:0] Z_EIGHTH  = Z_W'(64'sd536870912);
    localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(64'sd1073741824);
    localparam logic signed [Z_W-1:0] Z_HALF    = Z_W'(64'sd2147483648);

    // Special-case flags of one arctangent operand pair.
    typedef struct packed {
        logic zero;
        logic ay_zero;
        logic ax_zero;
        logic diag;
        logic x_neg;
        logic y_neg;
    } t_flags;

    // Magnitudes being normalized.
    typedef struct packed {
        logic [MAG_W-1:0] x;
        logic [MAG_W-1:0] y;
        logic [MAG_W-1:0] m;
    } t_nrm;

    // Rounded atan(2^-i) in units of 2^32 per turn.
    function automatic logic signed [Z_W-1:0] atan_tab(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = Z_W'(64'sd536870912);
            1:  v = Z_W'(64'sd316933406);
            2:  v = Z_W'(64'sd167458907);
            3:  v = Z_W'(64'sd85004756);
            4:  v = Z_W'(64'sd42667331);
            5:  v = Z_W'(64'sd21354465);
            6:  v = Z_W'(64'sd10679838);
            7:  v = Z_W'(64'sd5340245);
            8:  v = Z_W'(64'sd2670163);
            9:  v = Z_W'(64'sd1335087);
            10: v = Z_W'(64'sd667544);
            11: v = Z_W'(64'sd333772);
            12: v = Z_W'(64'sd166886);
            13: v = Z_W'(64'sd83443);
            14: v = Z_W'(64'sd41722);
            15: v = Z_W'(64'sd20861);
            16: v = Z_W'(64'sd10430);
            17: v = Z_W'(64'sd5215);
            18: v = Z_W'(64'sd2608);
            19: v = Z_W'(64'sd1304);
            20: v = Z_W'(64'sd652);
            21: v = Z_W'(64'sd326);
            22: v = Z_W'(64'sd163);
            default: v = Z_W'(64'sd81);
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/lookat_vec.sv
// Relative vector, squares and arctangent operands, three register stages.
`timescale 1ns / 1ps

module lookat_vec (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic signed [lookat_pkg::SUBJ_W-1:0]   i_subject_x,
    input  logic signed [lookat_pkg::SUBJ_W-1:0]   i_subject_y,
    input  logic signed [lookat_pkg::SUBJ_W-1:0]   i_subject_z,
    input  logic signed [lookat_pkg::EYE_W-1:0]    i_eye_x,
    input  logic signed [lookat_pkg::EYE_W-1:0]    i_eye_y,
    input  logic signed [lookat_pkg::EYE_W-1:0]    i_eye_z,
    output logic                                   o_valid,
    output logic signed [lookat_pkg::VEC_W-1:0]    o_head_y,
    output logic signed [lookat_pkg::VEC_W-1:0]    o_head_x,
    output logic signed [lookat_pkg::VEC_W-1:0]    o_tilt_y,
    output logic signed [lookat_pkg::VEC_W-1:0]    o_tilt_x
);

    localparam int D_W   = lookat_pkg::D_W;
    localparam int SQ_W  = 2 * D_W;
    localparam int VEC_W = lookat_pkg::VEC_W;
    localparam int HI    = lookat_pkg::SUBJ_W - 1;
    localparam int LO    = lookat_pkg::FRAC_W;

    logic [2:0] r_valid;

    logic signed [D_W-1:0]  r_dx, r_dy, r_dz;
    logic signed [D_W-1:0]  n_dx, n_dy, n_dz;
    logic signed [SQ_W-1:0] r_sq_x, r_sq_y, r_sq_z;
    logic signed [D_W-1:0]  r_hy2, r_hx2;
    logic                   r_dy_neg;
    logic signed [VEC_W-1:0] r_hy3, r_hx3, r_ty3, r_tx3;

    // Subject integer part is negated; camera is subtracted, Y is lifted.
    always_comb begin
        n_dx = -D_W'($signed(i_subject_x[HI:LO])) - D_W'(i_eye_x);
        n_dy = -D_W'($signed(i_subject_y[HI:LO])) - D_W'(i_eye_y)
               + D_W'(lookat_pkg::Y_LIFT);
        n_dz = -D_W'($signed(i_subject_z[HI:LO])) - D_W'(i_eye_z);
    end

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_dz <= n_dz;

        r_sq_x   <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_sq_y   <= SQ_W'(r_dy) * SQ_W'(r_dy);
        r_sq_z   <= SQ_W'(r_dz) * SQ_W'(r_dz);
        r_hy2    <= r_dx;
        r_hx2    <= r_dz;
        r_dy_neg <= r_dy[D_W-1];

        r_tx3 <= VEC_W'(r_sq_x) + VEC_W'(r_sq_z);
        r_ty3 <= r_dy_neg ? VEC_W'(r_sq_y) : -VEC_W'(r_sq_y);
        r_hy3 <= VEC_W'(r_hy2);
        r_hx3 <= VEC_W'(r_hx2);
    end

    assign o_valid  = r_valid[2];
    assign o_head_y = r_hy3;
    assign o_head_x = r_hx3;
    assign o_tilt_y = r_ty3;
    assign o_tilt_x = r_tx3;

endmodule

>>> rtl/core/lookat_atan.sv
// Pipelined atan2: magnitude, normalize, CORDIC vectoring, quadrant fix.
`timescale 1ns / 1ps

module lookat_atan #(
    parameter int CORDIC_STEPS = lookat_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = lookat_pkg::ANGLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [lookat_pkg::VEC_W-1:0] i_y,
    input  logic signed [lookat_pkg::VEC_W-1:0] i_x,
    output logic                                o_valid,
    output logic signed [ANGLE_BITS:0]          o_angle
);

    localparam int VEC_W = lookat_pkg::VEC_W;
    localparam int MAG_W = lookat_pkg::MAG_W;
    localparam int CX_W  = lookat_pkg::CX_W;
    localparam int Z_W   = lookat_pkg::Z_W;
    localparam int STEPS = (CORDIC_STEPS > lookat_pkg::TAB_LEN) ?
                           lookat_pkg::TAB_LEN : CORDIC_STEPS;
    localparam int SHR   = 32 - ANGLE_BITS;

    // Shift all three left by k when the top k bits of the maximum are clear.
    function automatic lookat_pkg::t_nrm nstep(input lookat_pkg::t_nrm a, input int k);
        lookat_pkg::t_nrm r;
        r = a;
        if ((a.m >> (MAG_W - k)) == '0) begin
            r.x = a.x << k;
            r.y = a.y << k;
            r.m = a.m << k;
        end
        return r;
    endfunction

    // Magnitude stage.
    logic [VEC_W-1:0]   n_ax, n_ay;
    lookat_pkg::t_flags n_fl;
    lookat_pkg::t_nrm   r_n0;
    lookat_pkg::t_flags r_fl0;
    logic               r_v0;

    always_comb begin
        n_ax = i_x[VEC_W-1] ? VEC_W'(-i_x) : VEC_W'(i_x);
        n_ay = i_y[VEC_W-1] ? VEC_W'(-i_y) : VEC_W'(i_y);
        n_fl.ay_zero = (n_ay == '0);
        n_fl.ax_zero = (n_ax == '0);
        n_fl.zero    = n_fl.ay_zero && n_fl.ax_zero;
        n_fl.diag    = (n_ax == n_ay);
        n_fl.x_neg   = i_x[VEC_W-1];
        n_fl.y_neg   = i_y[VEC_W-1];
    end

    always_ff @(posedge i_clk) begin
        r_n0.x <= MAG_W'(n_ax);
        r_n0.y <= MAG_W'(n_ay);
        r_n0.m <= MAG_W'((n_ax > n_ay) ? n_ax : n_ay);
        r_fl0  <= n_fl;
    end

    // Normalize in three stages, two shift steps each.
    lookat_pkg::t_nrm   r_n1, r_n2, r_n3;
    lookat_pkg::t_flags r_fl1, r_fl2, r_fl3;
    logic               r_v1, r_v2, r_v3;

    always_ff @(posedge i_clk) begin
        r_n1  <= nstep(nstep(r_n0, 32), 16);
        r_n2  <= nstep(nstep(r_n1, 8), 4);
        r_n3  <= nstep(nstep(r_n2, 2), 1);
        r_fl1 <= r_fl0;
        r_fl2 <= r_fl1;
        r_fl3 <= r_fl2;
    end

    // Rotation stages, one iteration each.
    logic signed [CX_W-1:0] w_cx [0:STEPS];
    logic signed [CX_W-1:0] w_cy [0:STEPS];
    logic signed [Z_W-1:0]  w_z  [0:STEPS];
    lookat_pkg::t_flags     w_fl [0:STEPS];
    logic                   w_v  [0:STEPS];

    assign w_cx[0] = CX_W'(r_n3.x);
    assign w_cy[0] = CX_W'(r_n3.y);
    assign w_z[0]  = '0;
    assign w_fl[0] = r_fl3;
    assign w_v[0]  = r_v3;

    for (genvar g = 0; g < STEPS; g++) begin : g_rot
        logic signed [CX_W-1:0] r_cx, r_cy;
        logic signed [Z_W-1:0]  r_z;
        lookat_pkg::t_flags     r_fl;
        logic                   r_v;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!w_cy[g][CX_W-1]) begin
                r_cx <= w_cx[g] + (w_cy[g] >>> g);
                r_cy <= w_cy[g] - (w_cx[g] >>> g);
                r_z  <= w_z[g] + lookat_pkg::atan_tab(g);
            end else begin
                r_cx <= w_cx[g] - (w_cy[g] >>> g);
                r_cy <= w_cy[g] + (w_cx[g] >>> g);
                r_z  <= w_z[g] - lookat_pkg::atan_tab(g);
            end
            r_fl <= w_fl[g];
        end

        assign w_cx[g+1] = r_cx;
        assign w_cy[g+1] = r_cy;
        assign w_z[g+1]  = r_z;
        assign w_fl[g+1] = r_fl;
        assign w_v[g+1]  = r_v;
    end

    // Special cases, clamp, quadrant and scaling to the output units.
    lookat_pkg::t_flags     c_fl;
    logic signed [Z_W-1:0]  c_z, c_sel, c_q;
    logic [ANGLE_BITS:0]    c_mag;
    logic signed [ANGLE_BITS:0] n_angle, r_angle;
    logic                   r_vo;

    always_comb begin
        c_fl = w_fl[STEPS];
        c_z  = w_z[STEPS];
        if (c_z[Z_W-1]) begin
            c_z = '0;
        end else if (c_z > lookat_pkg::Z_QUARTER) begin
            c_z = lookat_pkg::Z_QUARTER;
        end
        if (c_fl.ay_zero) begin
            c_sel = '0;
        end else if (c_fl.ax_zero) begin
            c_sel = lookat_pkg::Z_QUARTER;
        end else if (c_fl.diag) begin
            c_sel = lookat_pkg::Z_EIGHTH;
        end else begin
            c_sel = c_z;
        end
        c_q   = c_fl.x_neg ? (lookat_pkg::Z_HALF - c_sel) : c_sel;
        c_mag = c_q[SHR +: ANGLE_BITS+1];
        if (c_fl.zero) begin
            n_angle = '0;
        end else if (c_fl.y_neg) begin
            n_angle = -$signed(c_mag);
        end else begin
            n_angle = $signed(c_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle <= n_angle;
    end

    // Valid bits of the fixed stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= w_v[STEPS];
        end
    end

    assign o_valid = r_vo;
    assign o_angle = r_angle;

endmodule

>>> rtl/core/look_at_yaw_pitch_angles_core.sv
// Top level of the look-at yaw and pitch angle core.
`timescale 1ns / 1ps

// The core takes one word whenever start is high and never raises busy. Each
// word yields one result, marked by a one-cycle o_done pulse; the receiver
// must take it in that cycle. Each word passes through the two parallel atan2
// pipelines: one stage for magnitudes, three for normalizing, one per CORDIC
// step and one for the quadrant fix, behind three stages that form the
// relative vector and its squares, plus the output register.

module look_at_yaw_pitch_angles_core #(
    parameter int CORDIC_STEPS = lookat_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = lookat_pkg::ANGLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [lookat_pkg::SUBJ_W-1:0]   i_subject_x,
    input  logic signed [lookat_pkg::SUBJ_W-1:0]   i_subject_y,
    input  logic signed [lookat_pkg::SUBJ_W-1:0]   i_subject_z,
    input  logic signed [lookat_pkg::EYE_W-1:0]    i_eye_x,
    input  logic signed [lookat_pkg::EYE_W-1:0]    i_eye_y,
    input  logic signed [lookat_pkg::EYE_W-1:0]    i_eye_z,
    output logic                                   o_done,
    output logic signed [lookat_pkg::SCALE_W-1:0]  o_scaled_x,
    output logic signed [lookat_pkg::SCALE_W-1:0]  o_scaled_y,
    output logic signed [lookat_pkg::SCALE_W-1:0]  o_scaled_z,
    output logic [ANGLE_BITS:0]                    o_heading_angle,
    output logic signed [ANGLE_BITS-1:0]           o_tilt_angle
);

    localparam int STEPS = (CORDIC_STEPS > lookat_pkg::TAB_LEN) ?
                           lookat_pkg::TAB_LEN : CORDIC_STEPS;
    localparam int LAT   = lookat_pkg::VEC_LAT + lookat_pkg::ATAN_FIX_LAT + STEPS;
    localparam int VEC_W = lookat_pkg::VEC_W;
    localparam int SC_W  = lookat_pkg::SCALE_W;
    localparam int ES    = lookat_pkg::EYE_SHIFT;

    logic                    v_valid;
    logic signed [VEC_W-1:0] v_hy, v_hx, v_ty, v_tx;
    logic                    h_valid, t_valid;
    logic signed [ANGLE_BITS:0] h_angle, t_angle;

    // The pipeline takes a word every cycle.
    assign busy = 1'b0;

    lookat_vec u_vec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start),
        .i_subject_x (i_subject_x),
        .i_subject_y (i_subject_y),
        .i_subject_z (i_subject_z),
        .i_eye_x     (i_eye_x),
        .i_eye_y     (i_eye_y),
        .i_eye_z     (i_eye_z),
        .o_valid     (v_valid),
        .o_head_y    (v_hy),
        .o_head_x    (v_hx),
        .o_tilt_y    (v_ty),
        .o_tilt_x    (v_tx)
    );

    lookat_atan #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_valid),
        .i_y     (v_hy),
        .i_x     (v_hx),
        .o_valid (h_valid),
        .o_angle (h_angle)
    );

    lookat_atan #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_tilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_valid),
        .i_y     (v_ty),
        .i_x     (v_tx),
        .o_valid (t_valid),
        .o_angle (t_angle)
    );

    // Scaled camera position rides a delay line alongside the angle pipes.
    logic signed [SC_W-1:0] r_ex [0:LAT-1];
    logic signed [SC_W-1:0] r_ey [0:LAT-1];
    logic signed [SC_W-1:0] r_ez [0:LAT-1];

    always_ff @(posedge i_clk) begin
        r_ex[0] <= {i_eye_x, ES'(0)};
        r_ey[0] <= {i_eye_y, ES'(0)};
        r_ez[0] <= {i_eye_z, ES'(0)};
        for (int k = 1; k < LAT; k++) begin
            r_ex[k] <= r_ex[k-1];
            r_ey[k] <= r_ey[k-1];
            r_ez[k] <= r_ez[k-1];
        end
    end

    // Output register.
    logic                          r_done;
    logic signed [SC_W-1:0]        r_sx, r_sy, r_sz;
    logic [ANGLE_BITS:0]           r_head;
    logic signed [ANGLE_BITS-1:0]  r_tilt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= h_valid && t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx   <= r_ex[LAT-1];
        r_sy   <= r_ey[LAT-1];
        r_sz   <= r_ez[LAT-1];
        r_head <= (ANGLE_BITS+1)'(h_angle) + ((ANGLE_BITS+1)'(1) << (ANGLE_BITS-1));
        r_tilt <= ANGLE_BITS'(-t_angle);
    end

    assign o_done          = r_done;
    assign o_scaled_x      = r_sx;
    assign o_scaled_y      = r_sy;
    assign o_scaled_z      = r_sz;
    assign o_heading_angle = r_head;
    assign o_tilt_angle    = r_tilt;

endmodule

>>> rtl/core/lookat_chk.sv
// Port-level checker of the look-at angle core and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lookat_chk #(
    parameter int CORDIC_STEPS = lookat_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = lookat_pkg::ANGLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic signed [lookat_pkg::SUBJ_W-1:0]   i_subject_x,
    input  logic signed [lookat_pkg::SUBJ_W-1:0]   i_subject_y,
    input  logic signed [lookat_pkg::SUBJ_W-1:0]   i_subject_z,
    input  logic signed [lookat_pkg::EYE_W-1:0]    i_eye_x,
    input  logic signed [lookat_pkg::EYE_W-1:0]    i_eye_y,
    input  logic signed [lookat_pkg::EYE_W-1:0]    i_eye_z,
    input  logic                                   o_done,
    input  logic signed [lookat_pkg::SCALE_W-1:0]  o_scaled_x,
    input  logic signed [lookat_pkg::SCALE_W-1:0]  o_scaled_y,
    input  logic signed [lookat_pkg::SCALE_W-1:0]  o_scaled_z,
    input  logic [ANGLE_BITS:0]                    o_heading_angle,
    input  logic signed [ANGLE_BITS-1:0]           o_tilt_angle
);

    localparam int STEPS = (CORDIC_STEPS > lookat_pkg::TAB_LEN) ?
                           lookat_pkg::TAB_LEN : CORDIC_STEPS;
    localparam int RES_LAT = lookat_pkg::VEC_LAT + lookat_pkg::ATAN_FIX_LAT + STEPS + 1;
    localparam logic [ANGLE_BITS:0] HEAD_MAX = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
    localparam logic signed [ANGLE_BITS-1:0] TILT_MAX = ANGLE_BITS'(1) << (ANGLE_BITS-2);

    // A result word always traces back to an accepted word.
    `ASSERT_IMPLIES(a_done_has_start, i_clk, i_rst_n, o_done, $past(start && !busy, RES_LAT), "result without a start")

    // The scaled camera position of a result is the delayed camera times sixteen.
    `ASSERT_IMPLIES(a_scaled_x, i_clk, i_rst_n, o_done, o_scaled_x == {$past(i_eye_x, RES_LAT), 4'b0000}, "scaled X mismatch")

    // Heading stays within one full turn.
    `ASSERT_IMPLIES(a_head_range, i_clk, i_rst_n, o_done, o_heading_angle <= HEAD_MAX, "heading out of range")

    // Tilt stays within a quarter turn either way.
    `ASSERT_IMPLIES(a_tilt_range, i_clk, i_rst_n, o_done, (o_tilt_angle <= TILT_MAX) && (o_tilt_angle >= -TILT_MAX), "tilt out of range")

endmodule

bind look_at_yaw_pitch_angles_core lookat_chk #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
) u_lookat_chk (.*);

>>> tb/sv/tb_look_at_yaw_pitch_angles_core.sv
// Self-checking testbench of the look-at yaw and pitch angle core.
`timescale 1ns / 1ps

module tb_look_at_yaw_pitch_angles_core;

    localparam int SUBJ_W    = lookat_pkg::SUBJ_W;
    localparam int EYE_W     = lookat_pkg::EYE_W;
    localparam int SCALE_W   = lookat_pkg::SCALE_W;
    localparam int FRAC_W    = lookat_pkg::FRAC_W;
    localparam int Y_LIFT    = lookat_pkg::Y_LIFT;
    localparam int STEPS     = (lookat_pkg::CORDIC_STEPS_DEF > lookat_pkg::TAB_LEN) ?
                               lookat_pkg::TAB_LEN : lookat_pkg::CORDIC_STEPS_DEF;
    localparam int ABITS     = lookat_pkg::ANGLE_BITS_DEF;
    localparam int N_RANDOM  = 400;
    localparam int LATENCY   = lookat_pkg::CORDIC_STEPS_DEF + 9;
    localparam int MAX_CYCLES = 200000;

    localparam longint TURN_QUARTER = 64'sd1 << 30;
    localparam longint TURN_EIGHTH  = 64'sd1 << 29;
    localparam longint TURN_HALF    = 64'sd1 << 31;

    // Rounded atan(2^-i), 2^32 units per turn.
    localparam longint ARC_STEP [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // One input word.
    typedef struct {
        logic signed [SUBJ_W-1:0] subj_x, subj_y, subj_z;
        logic signed [EYE_W-1:0]  eye_x, eye_y, eye_z;
        bit                       typed;
        logic [ABITS:0]           head;
        logic signed [ABITS-1:0]  tilt;
    } t_word;

    // One result word.
    typedef struct {
        logic signed [SCALE_W-1:0] sx, sy, sz;
        logic [ABITS:0]            head;
        logic signed [ABITS-1:0]   tilt;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [SUBJ_W-1:0] i_subject_x = '0, i_subject_y = '0, i_subject_z = '0;
    logic signed [EYE_W-1:0]  i_eye_x = '0, i_eye_y = '0, i_eye_z = '0;
    logic o_done;
    logic signed [SCALE_W-1:0] o_scaled_x, o_scaled_y, o_scaled_z;
    logic [ABITS:0]            o_heading_angle;
    logic signed [ABITS-1:0]   o_tilt_angle;

    t_angles pending_angles[$];
    int      mismatches = 0;
    int      cycles = 0;
    t_word   directed[$];

    look_at_yaw_pitch_angles_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_subject_x(i_subject_x), .i_subject_y(i_subject_y), .i_subject_z(i_subject_z),
        .i_eye_x(i_eye_x), .i_eye_y(i_eye_y), .i_eye_z(i_eye_z),
        .o_done(o_done), .o_scaled_x(o_scaled_x), .o_scaled_y(o_scaled_y),
        .o_scaled_z(o_scaled_z), .o_heading_angle(o_heading_angle),
        .o_tilt_angle(o_tilt_angle)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Fixed-point atan2 by CORDIC vectoring, truncated toward zero.
    function automatic longint turn_angle(longint y, longint x);
        longint ax, ay, z, cx, cy, m, tx, ty, mag;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        if (ax == 0 && ay == 0) return 0;
        if (ay == 0) begin
            z = 0;
        end else if (ax == 0) begin
            z = TURN_QUARTER;
        end else if (ax == ay) begin
            z = TURN_EIGHTH;
        end else begin
            cx = ax;
            cy = ay;
            m = (ax > ay) ? ax : ay;
            while (m < (64'sd1 << 52)) begin
                cx = cx <<< 1;
                cy = cy <<< 1;
                m = m <<< 1;
            end
            z = 0;
            for (int i = 0; i < STEPS; i++) begin
                tx = cy >>> i;
                ty = cx >>> i;
                if (cy >= 0) begin
                    cx = cx + tx;
                    cy = cy - ty;
                    z = z + ARC_STEP[i];
                end else begin
                    cx = cx - tx;
                    cy = cy + ty;
                    z = z - ARC_STEP[i];
                end
            end
            if (z < 0) z = 0;
            if (z > TURN_QUARTER) z = TURN_QUARTER;
        end
        if (x < 0) z = TURN_HALF - z;
        mag = z >>> (32 - ABITS);
        return (y < 0) ? -mag : mag;
    endfunction

    // Expected outputs of one word.
    function automatic t_angles look_angles(t_word w);
        t_angles r;
        longint dx, dy, dz, range_sq, f;
        dx = -(longint'(w.subj_x) >>> FRAC_W) - longint'(w.eye_x);
        dy = -(longint'(w.subj_y) >>> FRAC_W) - longint'(w.eye_y) + Y_LIFT;
        dz = -(longint'(w.subj_z) >>> FRAC_W) - longint'(w.eye_z);
        range_sq = dx * dx + dz * dz;
        f = (dy < 0) ? dy * dy : -(dy * dy);
        r.sx = SCALE_W'(longint'(w.eye_x) * 16);
        r.sy = SCALE_W'(longint'(w.eye_y) * 16);
        r.sz = SCALE_W'(longint'(w.eye_z) * 16);
        r.head = (ABITS + 1)'(turn_angle(dx, dz) + (64'sd1 << (ABITS - 1)));
        r.tilt = ABITS'(-turn_angle(f, range_sq));
        return r;
    endfunction

    function automatic t_word mk(longint sx, longint sy, longint sz,
                                 longint ex, longint ey, longint ez,
                                 bit typed, longint head, longint tilt);
        t_word w;
        w.subj_x = SUBJ_W'(sx); w.subj_y = SUBJ_W'(sy); w.subj_z = SUBJ_W'(sz);
        w.eye_x = EYE_W'(ex); w.eye_y = EYE_W'(ey); w.eye_z = EYE_W'(ez);
        w.typed = typed;
        w.head = (ABITS + 1)'(head);
        w.tilt = ABITS'(tilt);
        return w;
    endfunction

    // Subject near the camera, so that angles spread over the whole turn.
    function automatic t_word near_word();
        t_word w;
        longint ex, ey, ez, span;
        span = ($urandom_range(0, 3) == 0) ? 500000 : 300;
        ex = $signed(EYE_W'($urandom)) / 2;
        ey = $signed(EYE_W'($urandom)) / 2;
        ez = $signed(EYE_W'($urandom)) / 2;
        w.eye_x = EYE_W'(ex); w.eye_y = EYE_W'(ey); w.eye_z = EYE_W'(ez);
        w.subj_x = SUBJ_W'((-(ex + $signed($urandom_range(0, 2 * span)) - span) <<< 12)
                   | $urandom_range(0, 4095));
        w.subj_y = SUBJ_W'((-(ey - 40 + $signed($urandom_range(0, 2 * span)) - span) <<< 12)
                   | $urandom_range(0, 4095));
        w.subj_z = SUBJ_W'((-(ez + $signed($urandom_range(0, 2 * span)) - span) <<< 12)
                   | $urandom_range(0, 4095));
        w.typed = 1'b0;
        return w;
    endfunction

    // Drive one word and hold it until the core takes it.
    task automatic send_word(t_word w);
        t_angles e;
        i_subject_x <= w.subj_x; i_subject_y <= w.subj_y; i_subject_z <= w.subj_z;
        i_eye_x <= w.eye_x; i_eye_y <= w.eye_y; i_eye_z <= w.eye_z;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        e = look_angles(w);
        if (w.typed) begin
            e.head = w.head;
            e.tilt = w.tilt;
        end
        pending_angles.push_back(e);
    endtask

    task automatic maybe_idle(bit quiet);
        while (!quiet && $urandom_range(0, 99) < 6) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_angles e;
        if (i_rst_n && o_done) begin
            if (pending_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result word at cycle %0d", cycles);
            end else begin
                e = pending_angles.pop_front();
                if (o_scaled_x !== e.sx || o_scaled_y !== e.sy || o_scaled_z !== e.sz ||
                    o_heading_angle !== e.head || o_tilt_angle !== e.tilt) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: exp %0d %0d %0d head %0d tilt %0d, ",
                                  "got %0d %0d %0d head %0d tilt %0d"},
                                 e.sx, e.sy, e.sz, e.head, e.tilt, o_scaled_x, o_scaled_y,
                                 o_scaled_z, o_heading_angle, o_tilt_angle);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int waited;
        // Zero vector, level vector, the negative-z axis, diagonals and extremes.
        directed.push_back(mk(0, 0, 0, 0, 0, 0, 1, 2048, 1024));
        directed.push_back(mk(0, 0, 0, 0, 40, 0, 1, 2048, 0));
        directed.push_back(mk(0, 0, 0, 0, 40, 1, 1, 4096, 0));
        directed.push_back(mk(0, 0, 0, 0, 40, -1, 1, 2048, 0));
        directed.push_back(mk(0, 0, 0, -1, 40, 0, 1, 3072, 0));
        directed.push_back(mk(0, 0, 0, 1, 40, 0, 1, 1024, 0));
        directed.push_back(mk(0, 0, 0, -5, 40, -5, 1, 2560, 0));
        directed.push_back(mk(0, 0, 0, 5, 40, 5, 1, 512, 0));
        directed.push_back(mk(0, 0, 0, -5, 0, -5, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, -5, 80, -5, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, -3, 37, 3, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, -524288, -524288, -524288, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, 524287, 524287, 524287, 0, 0, 0));
        directed.push_back(mk(-2147483648, -2147483648, -2147483648, 524287, 524287, 524287,
                              0, 0, 0));
        directed.push_back(mk(2147483647, 2147483647, 2147483647, -524288, -524288, -524288,
                              0, 0, 0));
        directed.push_back(mk(-2147483648, 2147483647, -2147483648, -524288, 0, 524287,
                              0, 0, 0));
        directed.push_back(mk(4095, 4095, 4095, 0, 40, 0, 0, 0, 0));
        directed.push_back(mk(-1, -1, -1, 0, 40, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, -4096, 0, 40, 0, 1, 2048, 0));
        directed.push_back(mk(-7 * 4096, 0, -1000 * 4096, 0, 40, 0, 0, 0, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_word(directed[k]);
            maybe_idle(1'b0);
        end

        // Random words; a middle stretch runs back to back.
        for (int n = 0; n < N_RANDOM; n++) begin
            t_word w;
            if ($urandom_range(0, 2) == 0) begin
                w.subj_x = SUBJ_W'($urandom); w.subj_y = SUBJ_W'($urandom);
                w.subj_z = SUBJ_W'($urandom);
                w.eye_x = EYE_W'($urandom); w.eye_y = EYE_W'($urandom);
                w.eye_z = EYE_W'($urandom);
                w.typed = 1'b0;
            end else begin
                w = near_word();
            end
            send_word(w);
            maybe_idle(n >= 150 && n < 300);
        end
        start <= 1'b0;

        waited = 0;
        while (pending_angles.size() != 0 && waited < 10 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 5) @(posedge i_clk);

        if (mismatches == 0 && pending_angles.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
